/* hdl/sn7seg_pkg.sv */
`default_nettype none
package sn7seg_pkg;

  localparam int NUM_POS = 6;

  localparam logic [7:0] DOT_BIT     = 8'h80;
  localparam logic [7:0] MINUS_GLYPH = 8'h40;
  localparam logic [7:0] BLANK_GLYPH = 8'h00;

  localparam logic [0:0] LAYOUT_FOUR = 1'b0;
  localparam logic [0:0] LAYOUT_SIX  = 1'b1;

  localparam logic [2:0] USED_FOUR = 3'd4;

  typedef struct packed {
    logic signed [31:0] value;
    logic               zero_fill;
    logic signed [3:0]  dot_index;
  } sn7seg_in_t;

  typedef struct packed {
    logic [7:0] seg_pos0;
    logic [7:0] seg_pos1;
    logic [7:0] seg_pos2;
    logic [7:0] seg_pos3;
    logic [7:0] seg_pos4;
    logic [7:0] seg_pos5;
    logic [2:0] used_positions;
  } sn7seg_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } sn7seg_cmd_t;

  typedef struct packed {
    logic last;
  } sn7seg_status_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h6f;
      default: g = BLANK_GLYPH;
    endcase
    return g;
  endfunction

  // display position for digit-order index k
  function automatic logic [2:0] pos_order(input logic layout, input logic [2:0] k);
    logic [2:0] p;
    if (layout == LAYOUT_SIX) begin
      unique case (k)
        3'd0:    p = 3'd3;
        3'd1:    p = 3'd4;
        3'd2:    p = 3'd5;
        3'd3:    p = 3'd0;
        3'd4:    p = 3'd1;
        3'd5:    p = 3'd2;
        default: p = 3'd0;
      endcase
    end else begin
      unique case (k)
        3'd0:    p = 3'd3;
        3'd1:    p = 3'd2;
        3'd2:    p = 3'd1;
        default: p = 3'd0;
      endcase
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* hdl/signed_number_to_seven_segment_top.sv */
// channel   | handshake                  | word
// ----------+----------------------------+-----------------------------------
// command   | start, busy                | operand (value, zero_fill, dot_index)
// result    | done (one-cycle strobe)    | result (seg_pos0..5, used_positions)
// config    | cfg_valid, cfg_ready       | cfg_data (layout)
//
// A word runs from start to done in this order: a load in IDLE, one divide-by-ten step
// per display position in RUN, then done in FIN.
// busy stays high from the accepting edge through the done cycle;
// cfg_ready = !busy && !start, so layout never changes under a word in work.
// rst is synchronous, active high; it clears the controller and sets layout to 0.
// The receiver cannot stall: the result is valid only during the done cycle.
`default_nettype none
module signed_number_to_seven_segment_top #(
  parameter int MAX_POSITIONS = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire sn7seg_pkg::sn7seg_in_t operand,
  output logic                        done,
  output sn7seg_pkg::sn7seg_out_t     result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  sn7seg_pkg::sn7seg_cmd_t    cmd;
  sn7seg_pkg::sn7seg_status_t status;

  assign cfg_ready = ~busy & ~start;

  sn7seg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  sn7seg_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .operand  (operand),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("accepted word not in work");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
`endif

endmodule
`default_nettype wire

/* hdl/sn7seg_ctrl.sv */
`default_nettype none
module sn7seg_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire sn7seg_pkg::sn7seg_status_t status,
  output sn7seg_pkg::sn7seg_cmd_t        cmd,
  output logic                           busy,
  output logic                           done
);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    RUN  = 3'b010,
    FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = RUN;
        end
      end
      RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = FIN;
        end
      end
      FIN: begin
        done       = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/sn7seg_dp.sv */
`default_nettype none
module sn7seg_dp #(
  parameter int MAX_POSITIONS = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_data,
  input  wire sn7seg_pkg::sn7seg_in_t     operand,
  input  wire sn7seg_pkg::sn7seg_cmd_t    cmd,
  output sn7seg_pkg::sn7seg_status_t      status,
  output sn7seg_pkg::sn7seg_out_t         result
);

  localparam logic [2:0] USED_SIX = 3'(MAX_POSITIONS < 6 ? MAX_POSITIONS : 6);
  localparam logic [63:0] RECIP10 = 64'hCCCC_CCCD;

  logic              layout;
  logic [31:0]       mag;
  logic              neg;
  logic              fill;
  logic signed [3:0] dot;
  logic [2:0]        k;
  logic [7:0]        buf_q [sn7seg_pkg::NUM_POS];

  logic [2:0]  used;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [7:0]  glyph;
  logic [2:0]  pos;

  assign used = (layout == sn7seg_pkg::LAYOUT_SIX) ? USED_SIX : sn7seg_pkg::USED_FOUR;

  // divide by ten through reciprocal multiply, exact for 32-bit unsigned
  assign prod = 64'(mag) * RECIP10;
  assign quot = 32'(prod[63:35]);
  assign rem  = 4'(mag - ((quot << 3) + (quot << 1)));

  assign pos         = sn7seg_pkg::pos_order(layout, k);
  assign status.last = (k == used - 3'd1);

  always_comb begin
    if (k == 3'd0 || mag != 32'd0) begin
      glyph = sn7seg_pkg::digit_glyph(rem);
    end else if (fill) begin
      glyph = sn7seg_pkg::digit_glyph(4'd0);
    end else begin
      glyph = sn7seg_pkg::BLANK_GLYPH;
    end
    if ($signed({1'b0, k}) == dot) begin
      glyph = glyph | sn7seg_pkg::DOT_BIT;
    end
    if (neg && status.last) begin
      glyph = sn7seg_pkg::MINUS_GLYPH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= sn7seg_pkg::LAYOUT_FOUR;
    end else if (cfg_we) begin
      layout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= operand.value[31];
      mag  <= operand.value[31] ? 32'(-operand.value) : operand.value;
      fill <= operand.zero_fill;
      dot  <= operand.dot_index;
      k    <= 3'd0;
      for (int i = 0; i < sn7seg_pkg::NUM_POS; i++) begin
        buf_q[i] <= sn7seg_pkg::BLANK_GLYPH;
      end
    end else if (cmd.step) begin
      mag        <= quot;
      k          <= k + 3'd1;
      buf_q[pos] <= glyph;
    end
  end

  assign result.seg_pos0       = buf_q[0];
  assign result.seg_pos1       = buf_q[1];
  assign result.seg_pos2       = buf_q[2];
  assign result.seg_pos3       = buf_q[3];
  assign result.seg_pos4       = buf_q[4];
  assign result.seg_pos5       = buf_q[5];
  assign result.used_positions = used;

endmodule
`default_nettype wire
